@@ src/assert_macros.svh @@
// Assertion macros shared by the case-fold substring filter RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/cfsf_pkg.sv @@
// Package for the case-fold substring filter: sizes, codes, shared types and
// the ASCII case-fold function. No dependencies.
package cfsf_pkg;

    // Window depth, one cell per needle character.
    localparam int NEEDLE_MAX = 16;
    localparam int LEN_W      = $clog2(NEEDLE_MAX + 1);
    localparam int IDX_W      = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

    // Field widths fixed by the interface.
    localparam int CH_W     = 8;
    localparam int KIND_W   = 2;
    localparam int CNT_W    = 16;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int NLEN_W   = 5;
    localparam int NVEC_W   = 2 * CFG_W;

    // Input word kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE    = 2'd0,
        KIND_END     = 2'd1,
        KIND_RESTART = 2'd2
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LOW    = 2'd0,
        CFG_NEEDLE_HIGH   = 2'd1,
        CFG_NEEDLE_LENGTH = 2'd2
    } cfg_index_t;

    // Control handed to every window cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // One result word.
    typedef struct packed {
        logic             keep;
        logic [CNT_W-1:0] record_index;
        logic [CNT_W-1:0] kept_slot;
    } result_t;

    // Fold A-Z to a-z; every other byte passes unchanged.
    function automatic logic [CH_W-1:0] fold_byte(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

@@ src/case_fold_substring_filter.sv @@
// Case-fold substring filter. Words arrive on the input channel (in_valid,
// in_stall, kind, ch); kind selects a name byte, the end of a name, or a
// restart of the list counters. Each byte is folded to lower case and shifted
// into a chain of NEEDLE_MAX cells; every cell compares the byte entering it
// with its needle character, and a full match sets a sticky hit for the name.
// An end-of-name word yields one result word on the output channel
// (out_valid, out_stall, keep, record_index, kept_slot) through the output
// buffer once it is accepted; bytes and restarts yield nothing.
// Throughput is one input word per cycle while in_stall is low, set by the
// shift and parallel compare across the cell chain.
// The needle registers are written through cfg_we, cfg_index and cfg_data.
// Reset clears the needle, window, hit flag and both counters.
// When the receiver stalls, the result waits in the output register and a
// second one in a skid register; in_stall rises only when both are occupied.
// Depends on cfsf_pkg, cfsf_cell, cfsf_out_buf and assert_macros.svh.
`include "assert_macros.svh"

module case_fold_substring_filter
    import cfsf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [KIND_W-1:0]    kind,
    input  logic [CH_W-1:0]      ch,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 keep,
    output logic [CNT_W-1:0]     record_index,
    output logic [CNT_W-1:0]     kept_slot,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0]  needle_low_reg;
    logic [CFG_W-1:0]  needle_high_reg;
    logic [NLEN_W-1:0] needle_length_reg;
    logic [LEN_W-1:0]  chars_seen_reg;
    logic [LEN_W-1:0]  chars_seen_next;
    logic              hit_reg;
    logic              hit_next;
    logic [CNT_W-1:0]  name_count_reg;
    logic [CNT_W-1:0]  name_count_next;
    logic [CNT_W-1:0]  kept_count_reg;
    logic [CNT_W-1:0]  kept_count_next;

    logic              accept;
    kind_t             kind_in;
    logic              is_byte;
    logic              is_end;
    logic              is_restart;
    cell_ctrl_t        ctrl;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  len_m1;
    logic [NVEC_W-1:0] needle_vec;
    logic [CH_W-1:0]   needle_fold [NEEDLE_MAX];
    logic [CH_W-1:0]   cell_in     [NEEDLE_MAX];
    logic [CH_W-1:0]   cell_out    [NEEDLE_MAX];
    logic [CH_W-1:0]   cell_needle [NEEDLE_MAX];
    logic              cell_use    [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] cell_match;
    logic              byte_hit;
    logic              keep_now;
    logic              push;
    logic              buf_full;
    result_t           push_data;
    result_t           out_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg    <= '0;
            needle_high_reg   <= '0;
            needle_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_NEEDLE_LOW:    needle_low_reg    <= cfg_data;
                CFG_NEEDLE_HIGH:   needle_high_reg   <= cfg_data;
                CFG_NEEDLE_LENGTH: needle_length_reg <= cfg_data[NLEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Input decode.
    assign accept     = in_valid && !in_stall;
    assign kind_in    = kind_t'(kind);
    assign is_byte    = (kind_in == KIND_BYTE);
    assign is_end     = (kind_in == KIND_END);
    assign is_restart = (kind_in == KIND_RESTART);
    assign ctrl.shift = accept && is_byte;
    assign ctrl.clear = accept && (is_end || is_restart);

    // Active needle length, saturated at the window depth.
    always_comb
    begin
        if (needle_length_reg > NLEN_W'(NEEDLE_MAX))
        begin
            len = LEN_W'(NEEDLE_MAX);
        end
        else
        begin
            len = LEN_W'(needle_length_reg);
        end
    end
    assign len_m1     = len - LEN_W'(1);
    assign needle_vec = {needle_high_reg, needle_low_reg};

    // Cell 0 sees the newest byte and cell k the one k places older, so cell k takes needle character len-1-k.
    for (genvar k = 0; k < NEEDLE_MAX; k++)
    begin : g_cell
        logic [IDX_W-1:0] sel;

        assign needle_fold[k] = fold_byte(needle_vec[k*CH_W +: CH_W]);
        assign sel            = len_m1[IDX_W-1:0] - IDX_W'(k);
        assign cell_use[k]    = (LEN_W'(k) < len);
        assign cell_needle[k] = needle_fold[sel];

        if (k == 0)
        begin : g_head
            assign cell_in[k] = fold_byte(ch);
        end
        else
        begin : g_link
            assign cell_in[k] = cell_out[k-1];
        end

        cfsf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .byte_in   (cell_in[k]),
            .needle_ch (cell_needle[k]),
            .in_use    (cell_use[k]),
            .byte_out  (cell_out[k]),
            .match     (cell_match[k])
        );
    end

    // Per-name length count and sticky hit.
    always_comb
    begin
        chars_seen_next = chars_seen_reg;
        hit_next        = hit_reg;
        byte_hit        = 1'b0;
        if (ctrl.clear)
        begin
            chars_seen_next = '0;
            hit_next        = 1'b0;
        end
        else if (ctrl.shift)
        begin
            if (chars_seen_reg < LEN_W'(NEEDLE_MAX))
            begin
                chars_seen_next = chars_seen_reg + LEN_W'(1);
            end
            byte_hit = (len != '0) && (chars_seen_next >= len) && (&cell_match);
            if (byte_hit)
            begin
                hit_next = 1'b1;
            end
        end
    end

    // List counters and the result word of a finished name.
    assign keep_now = (len == '0) || hit_reg;
    assign push     = accept && is_end;

    always_comb
    begin
        name_count_next = name_count_reg;
        kept_count_next = kept_count_reg;
        if (accept && is_restart)
        begin
            name_count_next = '0;
            kept_count_next = '0;
        end
        else if (push)
        begin
            name_count_next = name_count_reg + CNT_W'(1);
            if (keep_now)
            begin
                kept_count_next = kept_count_reg + CNT_W'(1);
            end
        end
    end

    assign push_data.keep         = keep_now;
    assign push_data.record_index = name_count_reg;
    assign push_data.kept_slot    = keep_now ? kept_count_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_seen_reg <= '0;
            hit_reg        <= 1'b0;
            name_count_reg <= '0;
            kept_count_reg <= '0;
        end
        else
        begin
            chars_seen_reg <= chars_seen_next;
            hit_reg        <= hit_next;
            name_count_reg <= name_count_next;
            kept_count_reg <= kept_count_next;
        end
    end

    // Output register with skid.
    cfsf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign in_stall     = buf_full;
    assign keep         = out_data.keep;
    assign record_index = out_data.record_index;
    assign kept_slot    = out_data.kept_slot;

    // A dropped name never carries a slot.
    `ASSERT_IMPLIES(a_slot_zero_when_dropped, out_valid && !keep, kept_slot == '0)
    // The byte count saturates at the window depth.
    `ASSERT_IMPLIES(a_chars_saturate, 1'b1, chars_seen_reg <= LEN_W'(NEEDLE_MAX))
    // Ending or restarting a name clears its per-name state.
    `ASSERT_NEXT(a_name_cleared, ctrl.clear, chars_seen_reg == '0 && !hit_reg)
    // A restart zeroes both list counters.
    `ASSERT_NEXT(a_restart_clears, accept && is_restart,
                 name_count_reg == '0 && kept_count_reg == '0)

endmodule

@@ src/cfsf_cell.sv @@
// One window cell of the case-fold substring filter: holds one folded byte,
// passes it to its neighbor on a shift and compares the incoming byte.
// Depends on cfsf_pkg.
module cfsf_cell
    import cfsf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cell_ctrl_t      ctrl,
    input  logic [CH_W-1:0] byte_in,
    input  logic [CH_W-1:0] needle_ch,
    input  logic            in_use,
    output logic [CH_W-1:0] byte_out,
    output logic            match
);

    logic [CH_W-1:0] byte_reg;
    logic [CH_W-1:0] byte_next;

    // The byte entering this cell on a shift is the one compared.
    assign match = !in_use || (byte_in == needle_ch);

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = '0;
        end
        else if (ctrl.shift)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

@@ src/cfsf_out_buf.sv @@
// Output stage of the case-fold substring filter: a main register and a skid
// register so the input side keeps running while a result word waits.
// Depends on cfsf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfsf_out_buf
    import cfsf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    main_valid_next;
    result_t main_data_reg;
    result_t main_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    pop;

    assign pop = main_valid_reg && !out_stall;

    // Refill the main register from the skid first, then from a new word.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // The skid only fills behind a waiting main word.
    `ASSERT_IMPLIES(a_skid_behind_main, skid_valid_reg, main_valid_reg)
    // No word arrives while the skid is occupied.
    `ASSERT_IMPLIES(a_no_push_when_full, push, !skid_valid_reg)
    // A drained main register is refilled from the skid.
    `ASSERT_NEXT(a_skid_refills, skid_valid_reg && !out_stall, main_valid_reg)

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for case_fold_substring_filter: directed words, then
// random phases of names under changing needles, with random idling on both sides.
// Depends on cfsf_pkg and the case_fold_substring_filter RTL.
module tb;
    import cfsf_pkg::*;

    // Kind code that the block has no use for; it must be ignored.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_WORDS  = 700;
    localparam int PHASE_WORDS   = 70;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MAX_REPORTS   = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [KIND_W-1:0]    kind;
    logic [CH_W-1:0]      ch;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 keep;
    logic [CNT_W-1:0]     record_index;
    logic [CNT_W-1:0]     kept_slot;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // One row of the directed table: either a register write or an input word.
    typedef struct {
        bit                is_cfg;
        cfg_index_t        reg_sel;
        logic [CFG_W-1:0]  value;
        logic [KIND_W-1:0] word_kind;
        logic [CH_W-1:0]   byte_val;
        bit                typed;
        result_t           want;
    } stim_row_t;

    // Needle registers and per-name state as the filter should hold them.
    logic [CFG_W-1:0]  needle_lo;
    logic [CFG_W-1:0]  needle_hi;
    logic [NLEN_W-1:0] needle_len;
    logic [CH_W-1:0]   recent [NEEDLE_MAX];
    int unsigned       seen;
    bit                name_hit;
    logic [CNT_W-1:0]  name_ord;
    logic [CNT_W-1:0]  kept_ord;

    result_t   due_results [$];
    result_t   oldest;
    stim_row_t directed [$];

    int  cycle_count;
    int  mismatch_count;
    int  words_sent;
    int  names_done;
    int  names_kept;
    int  restarts;
    int  ignored_words;
    int  settings_used;
    bit  steady;
    int  stall_left;

    case_fold_substring_filter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .ch           (ch),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .keep         (keep),
        .record_index (record_index),
        .kept_slot    (kept_slot),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Fold upper-case ASCII letters to lower case.
    function automatic logic [CH_W-1:0] lower_ascii(logic [CH_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    endfunction

    // Needle characters actually compared; oversized codes saturate.
    function automatic int unsigned needle_span();
        return (needle_len > NLEN_W'(NEEDLE_MAX)) ? NEEDLE_MAX : 32'(needle_len);
    endfunction

    function automatic void forget_name();
        int k;
        for (k = 0; k < NEEDLE_MAX; k++)
        begin
            recent[k] = '0;
        end
        seen     = 0;
        name_hit = 1'b0;
    endfunction

    // Advance the filter state by one accepted word; returns 1 with the result
    // of a finished name.
    function automatic bit track_word(logic [KIND_W-1:0] k, logic [CH_W-1:0] c,
                                      output result_t res);
        logic [NVEC_W-1:0] needle;
        int unsigned       span;
        bit                same;
        int                j;
        res    = '0;
        needle = {needle_hi, needle_lo};
        span   = needle_span();
        case (k)
            KIND_BYTE:
            begin
                for (j = NEEDLE_MAX - 1; j > 0; j--)
                begin
                    recent[j] = recent[j - 1];
                end
                recent[0] = lower_ascii(c);
                if (seen < NEEDLE_MAX)
                begin
                    seen++;
                end
                // The newest span bytes, oldest first, against the needle.
                if (span > 0 && seen >= span)
                begin
                    same = 1'b1;
                    for (j = 0; j < span; j++)
                    begin
                        if (recent[span - 1 - j] != lower_ascii(needle[8 * j +: 8]))
                        begin
                            same = 1'b0;
                        end
                    end
                    if (same)
                    begin
                        name_hit = 1'b1;
                    end
                end
            end
            KIND_END:
            begin
                res.keep         = (span == 0) || name_hit;
                res.record_index = name_ord;
                res.kept_slot    = res.keep ? kept_ord : '0;
                name_ord++;
                if (res.keep)
                begin
                    kept_ord++;
                end
                forget_name();
                return 1'b1;
            end
            KIND_RESTART:
            begin
                name_ord = '0;
                kept_ord = '0;
                forget_name();
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void note_mismatch(string what, logic [CNT_W-1:0] want,
                                          logic [CNT_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("Mismatch in %s at cycle %0d: expected %0h, got %0h",
                     what, cycle_count, want, got);
        end
    endfunction

    function automatic stim_row_t word_row(logic [KIND_W-1:0] k, logic [CH_W-1:0] c);
        stim_row_t r;
        r.is_cfg    = 1'b0;
        r.reg_sel   = CFG_NEEDLE_LOW;
        r.value     = '0;
        r.word_kind = k;
        r.byte_val  = c;
        r.typed     = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    function automatic stim_row_t end_row(logic k, logic [CNT_W-1:0] idx,
                                          logic [CNT_W-1:0] slot);
        stim_row_t r;
        r                   = word_row(KIND_END, 8'h00);
        r.typed             = 1'b1;
        r.want.keep         = k;
        r.want.record_index = idx;
        r.want.kept_slot    = slot;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(cfg_index_t sel, logic [CFG_W-1:0] value);
        stim_row_t r;
        r         = word_row(KIND_UNUSED, 8'h00);
        r.is_cfg  = 1'b1;
        r.reg_sel = sel;
        r.value   = value;
        return r;
    endfunction

    // Half the time a letter from a tiny alphabet, so partial matches are common.
    function automatic logic [CH_W-1:0] filler_byte();
        if ($urandom_range(1))
        begin
            return CH_W'(8'h41 + $urandom_range(1) + ($urandom_range(1) ? 8'h20 : 8'h00));
        end
        return CH_W'($urandom_range(255));
    endfunction

    function automatic logic [CH_W-1:0] swap_case(logic [CH_W-1:0] c);
        if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(1))
        begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // Send one word, with an occasional gap in front of it, and record what
    // the filter owes for it once it is accepted.
    task automatic send_word(logic [KIND_W-1:0] k, logic [CH_W-1:0] c, bit typed,
                             result_t want);
        result_t res;
        if (!steady && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        ch       <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (track_word(k, c, res))
        begin
            due_results.push_back(typed ? want : res);
        end
        case (k)
            KIND_END:     names_done++;
            KIND_RESTART: restarts++;
            default:
            begin
            end
        endcase
        if (k == KIND_UNUSED)
        begin
            ignored_words++;
        end
        else
        begin
            words_sent++;
        end
    endtask

    // Hold the input until every owed result is out, then let the block settle.
    task automatic settle();
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t sel, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (sel)
            CFG_NEEDLE_LOW:    needle_lo  = value;
            CFG_NEEDLE_HIGH:   needle_hi  = value;
            CFG_NEEDLE_LENGTH: needle_len = value[NLEN_W-1:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    // Needle setting for one random phase; the early phases hit the extremes.
    task automatic pick_needle(int phase);
        logic [NVEC_W-1:0] bytes;
        logic [NLEN_W-1:0] code;
        logic [CFG_W-1:0]  noise;
        int                k;
        for (k = 0; k < NEEDLE_MAX; k++)
        begin
            bytes[8 * k +: 8] = filler_byte();
        end
        case (phase)
            0: code = 5'd16;
            1: code = 5'd31;
            2: code = 5'd0;
            3:
            begin
                bytes = {{CFG_W{1'b1}}, {CFG_W{1'b0}}};
                code  = 5'd17;
            end
            4: code = 5'd1;
            5:
            begin
                bytes = {{CFG_W{1'b0}}, {CFG_W{1'b1}}};
                code  = 5'd16;
            end
            default: code = NLEN_W'(($urandom_range(99) < 80) ? $urandom_range(1, 8)
                                                               : $urandom_range(0, 31));
        endcase
        // Upper bits of the length write carry noise that must be dropped.
        noise = {$urandom, $urandom};
        write_reg(CFG_NEEDLE_LOW, bytes[CFG_W-1:0]);
        write_reg(CFG_NEEDLE_HIGH, bytes[NVEC_W-1:CFG_W]);
        write_reg(CFG_NEEDLE_LENGTH, {noise[CFG_W-1:NLEN_W], code});
        settings_used++;
    endtask

    // One name: mostly the needle in random case between random bytes, some
    // broken copies, some plain noise; rarely cut short by a restart.
    task automatic send_name();
        logic [CH_W-1:0]   body [$];
        logic [NVEC_W-1:0] needle;
        logic [KIND_W-1:0] closing;
        int unsigned       span;
        result_t           none;
        int                j;
        span   = needle_span();
        needle = {needle_hi, needle_lo};
        none   = '0;
        if ($urandom_range(99) < 60)
        begin
            repeat ($urandom_range(0, 6)) body.push_back(filler_byte());
            for (j = 0; j < span; j++)
            begin
                body.push_back(swap_case(needle[8 * j +: 8]));
            end
            repeat ($urandom_range(0, 6)) body.push_back(filler_byte());
            if ($urandom_range(99) < 10 && body.size() > 0)
            begin
                body[$urandom_range(body.size() - 1)] = CH_W'($urandom_range(255));
            end
        end
        else if ($urandom_range(99) < 25)
        begin
            repeat ($urandom_range(0, 20)) body.push_back(filler_byte());
        end
        foreach (body[j])
        begin
            if ($urandom_range(99) < 2)
            begin
                send_word(KIND_UNUSED, CH_W'($urandom_range(255)), 1'b0, none);
            end
            send_word(KIND_BYTE, body[j], 1'b0, none);
        end
        closing = ($urandom_range(99) < 3) ? KIND_RESTART : KIND_END;
        send_word(closing, CH_W'($urandom_range(255)), 1'b0, none);
    endtask

    // Receiver stalls come in bursts; none during the steady stretch.
    always @(posedge clk)
    begin
        if (steady)
        begin
            stall_left = 0;
        end
        else if (stall_left == 0 && $urandom_range(99) < 5)
        begin
            stall_left = $urandom_range(1, 8);
        end
        out_stall <= (stall_left != 0);
        if (stall_left != 0)
        begin
            stall_left--;
        end
    end

    // Compare every accepted result word with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                note_mismatch("unexpected result record_index", '0, record_index);
            end
            else
            begin
                oldest = due_results.pop_front();
                if (keep !== oldest.keep)
                begin
                    note_mismatch("keep", CNT_W'(oldest.keep), CNT_W'(keep));
                end
                if (record_index !== oldest.record_index)
                begin
                    note_mismatch("record_index", oldest.record_index, record_index);
                end
                if (kept_slot !== oldest.kept_slot)
                begin
                    note_mismatch("kept_slot", oldest.kept_slot, kept_slot);
                end
                if (oldest.keep)
                begin
                    names_kept++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("case_fold_substring_filter test failed");
            $finish;
        end
    end

    initial
    begin
        int        phase;
        int        phase_start;
        stim_row_t row;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_BYTE;
        ch         = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_NEEDLE_LOW;
        cfg_data   = '0;
        steady     = 1'b0;
        stall_left = 0;
        needle_lo  = '0;
        needle_hi  = '0;
        needle_len = '0;
        name_ord   = '0;
        kept_ord   = '0;
        forget_name();

        // Directed words: empty needle, a three-letter needle in mixed case,
        // a name too short, an ignored kind, zero and all-ones bytes, a
        // restart, and a length change while a name is half streamed.
        directed.push_back(end_row(1'b1, 16'd0, 16'd0));
        directed.push_back(word_row(KIND_BYTE, "x"));
        directed.push_back(end_row(1'b1, 16'd1, 16'd1));
        directed.push_back(cfg_row(CFG_NEEDLE_LOW, 64'h0000_0000_0063_4241));
        directed.push_back(cfg_row(CFG_NEEDLE_LENGTH, 64'd3));
        directed.push_back(word_row(KIND_BYTE, "a"));
        directed.push_back(word_row(KIND_BYTE, "b"));
        directed.push_back(word_row(KIND_BYTE, "C"));
        directed.push_back(end_row(1'b1, 16'd2, 16'd2));
        directed.push_back(word_row(KIND_BYTE, "a"));
        directed.push_back(word_row(KIND_BYTE, "b"));
        directed.push_back(word_row(KIND_UNUSED, 8'hFF));
        directed.push_back(end_row(1'b0, 16'd3, 16'd0));
        directed.push_back(word_row(KIND_BYTE, 8'h00));
        directed.push_back(word_row(KIND_BYTE, 8'hFF));
        directed.push_back(end_row(1'b0, 16'd4, 16'd0));
        directed.push_back(word_row(KIND_RESTART, 8'h00));
        directed.push_back(word_row(KIND_BYTE, "a"));
        directed.push_back(word_row(KIND_BYTE, "b"));
        directed.push_back(word_row(KIND_BYTE, "c"));
        directed.push_back(cfg_row(CFG_NEEDLE_LENGTH, 64'd16));
        directed.push_back(end_row(1'b1, 16'd0, 16'd0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[phase])
        begin
            row = directed[phase];
            if (row.is_cfg)
            begin
                settle();
                write_reg(row.reg_sel, row.value);
            end
            else
            begin
                send_word(row.word_kind, row.byte_val, row.typed, row.want);
            end
        end

        // Random phases, each under its own needle; one runs without idling.
        words_sent = 0;
        phase      = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            settle();
            steady = (phase == 3);
            pick_needle(phase);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS && words_sent < RANDOM_WORDS)
            begin
                send_name();
            end
            phase++;
        end
        steady = 1'b0;
        settle();

        $display("Ran %0d names (%0d kept), %0d restarts and %0d ignored words",
                 names_done, names_kept, restarts, ignored_words);
        $display("under %0d random needle settings after the directed table.",
                 settings_used);
        if (mismatch_count == 0 && due_results.size() == 0)
        begin
            $display("case_fold_substring_filter test passed");
        end
        else
        begin
            $display("case_fold_substring_filter test failed");
        end
        $finish;
    end

endmodule

@@ case_fold_substring_filter.f @@
+incdir+src
src/cfsf_pkg.sv
src/cfsf_cell.sv
src/cfsf_out_buf.sv
src/case_fold_substring_filter.sv
tb/tb.sv
